[src/bxc_pkg.sv]
// Shared constants, request and status codes, and beat types for the character buffer.
`default_nettype none
package bxc_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = 7;
  localparam int POS_W    = 7;
  localparam int CHAR_W   = 8;
  localparam int GRP      = 8;
  localparam int NGROUPS  = (CAPACITY + GRP - 1) / GRP;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_ERASE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_value;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] last_char;
    logic [LEN_W-1:0]  length_now;
    logic              is_empty;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic              ins;
    logic              ers;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             last_en;
    logic [IDX_W-1:0] last_idx;
  } sel_t;

endpackage
`default_nettype wire

[src/bxc_cell.sv]
// One character cell of the buffer chain with its read and last-character masks.
`default_nettype none
module bxc_cell (
  input  wire                          clk,
  input  bxc_pkg::cmd_t                cmd,
  input  bxc_pkg::sel_t                sel,
  input  wire  [bxc_pkg::IDX_W-1:0]    idx,
  input  wire  [bxc_pkg::CHAR_W-1:0]   lower_data,
  input  wire  [bxc_pkg::CHAR_W-1:0]   upper_data,
  output logic [bxc_pkg::CHAR_W-1:0]   data,
  output logic [bxc_pkg::CHAR_W-1:0]   rd_mask,
  output logic [bxc_pkg::CHAR_W-1:0]   last_mask
);
  import bxc_pkg::*;

  logic [CHAR_W-1:0] data_r, data_nxt;
  logic [CHAR_W-1:0] rd_mask_r, rd_mask_nxt;
  logic [CHAR_W-1:0] last_mask_r, last_mask_nxt;
  logic [LEN_W-1:0]  idx_w;

  assign idx_w = LEN_W'(idx);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (idx_w == LEN_W'(cmd.pos)) begin
        data_nxt = cmd.ch;
      end else if (idx_w > LEN_W'(cmd.pos) && idx_w <= cmd.len) begin
        data_nxt = lower_data;
      end
    end else if (cmd.ers) begin
      if (idx_w >= LEN_W'(cmd.pos) && (idx_w + LEN_W'(1)) < cmd.len) begin
        data_nxt = upper_data;
      end
    end
  end

  always_comb begin
    rd_mask_nxt   = (sel.rd_en && idx == sel.rd_idx) ? data_r : '0;
    last_mask_nxt = (sel.last_en && idx == sel.last_idx) ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    rd_mask_r   <= rd_mask_nxt;
    last_mask_r <= last_mask_nxt;
  end

  assign data      = data_r;
  assign rd_mask   = rd_mask_r;
  assign last_mask = last_mask_r;

endmodule
`default_nettype wire

[src/bxc_gather.sv]
// Registered OR tree that collects the masked read and last characters from the cells.
`default_nettype none
module bxc_gather (
  input  wire                                        clk,
  input  wire  [bxc_pkg::CAPACITY-1:0][bxc_pkg::CHAR_W-1:0] rd_mask,
  input  wire  [bxc_pkg::CAPACITY-1:0][bxc_pkg::CHAR_W-1:0] last_mask,
  output logic [bxc_pkg::CHAR_W-1:0]                 rd_char,
  output logic [bxc_pkg::CHAR_W-1:0]                 last_char
);
  import bxc_pkg::*;

  logic [NGROUPS-1:0][CHAR_W-1:0] rd_grp_r, rd_grp_nxt;
  logic [NGROUPS-1:0][CHAR_W-1:0] last_grp_r, last_grp_nxt;

  always_comb begin
    rd_grp_nxt   = '0;
    last_grp_nxt = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          rd_grp_nxt[g]   = rd_grp_nxt[g] | rd_mask[g * GRP + k];
          last_grp_nxt[g] = last_grp_nxt[g] | last_mask[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_grp_r   <= rd_grp_nxt;
    last_grp_r <= last_grp_nxt;
  end

  always_comb begin
    rd_char   = '0;
    last_char = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_char   = rd_char | rd_grp_r[g];
      last_char = last_char | last_grp_r[g];
    end
  end

endmodule
`default_nettype wire

[src/char_buffer_insert_erase.sv]
// Top level of the bounded character buffer with insert, erase, read and clear.
// A request beat is taken when start is high and busy is low. All cells shift
// together at that edge; the result then passes the cell mask registers, the group
// registers of a two-level OR tree and the output register, and out_strobe rises
// in the same cycle that busy falls; a new request is taken only once busy is low.
// The result is shown for exactly one cycle and cannot be held off.
`default_nettype none
module char_buffer_insert_erase (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  bxc_pkg::in_t   in_item,
  output logic           out_strobe,
  output bxc_pkg::out_t  out_item
);
  import bxc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MASK = 2'd1;
  localparam logic [1:0] PH_GRP  = 2'd2;
  localparam logic [1:0] PH_OUT  = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [1:0]       status_r, status_nxt;
  sel_t             sel_r, sel_nxt;
  logic             strobe_r, strobe_nxt;
  out_t             out_r, out_nxt;
  logic             accept;
  logic             ins, ers;
  logic [POS_W-1:0] ins_pos;
  logic [LEN_W-1:0] last_pos;
  cmd_t             cmd;

  logic [CAPACITY-1:0][CHAR_W-1:0] cell_data, cell_rd, cell_last;
  logic [CHAR_W-1:0]               rd_char, last_char;

  assign accept = start && (phase_r == PH_IDLE);

  always_comb begin
    len_nxt         = len_r;
    status_nxt      = ST_OK;
    ins             = 1'b0;
    ers             = 1'b0;
    ins_pos         = in_item.position;
    sel_nxt         = sel_r;
    sel_nxt.rd_en   = 1'b0;
    sel_nxt.rd_idx  = in_item.position[IDX_W-1:0];
    case (in_item.req_type)
      REQ_APPEND: begin
        ins_pos = POS_W'(len_r);
        if (len_r >= LEN_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          ins     = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      REQ_POP: begin
        if (len_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          len_nxt = len_r - LEN_W'(1);
        end
      end
      REQ_INSERT: begin
        if (LEN_W'(in_item.position) > len_r) begin
          status_nxt = ST_RANGE;
        end else if (len_r >= LEN_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          ins     = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      REQ_ERASE: begin
        if (LEN_W'(in_item.position) >= len_r) begin
          status_nxt = ST_RANGE;
        end else begin
          ers     = 1'b1;
          len_nxt = len_r - LEN_W'(1);
        end
      end
      REQ_READ: begin
        if (LEN_W'(in_item.position) >= len_r) begin
          status_nxt = ST_RANGE;
        end else begin
          sel_nxt.rd_en = 1'b1;
        end
      end
      REQ_CLEAR: begin
        len_nxt = '0;
      end
      default: begin
      end
    endcase
    last_pos         = len_nxt - LEN_W'(1);
    sel_nxt.last_en  = (len_nxt != '0);
    sel_nxt.last_idx = last_pos[IDX_W-1:0];
  end

  assign cmd.ins = accept && ins;
  assign cmd.ers = accept && ers;
  assign cmd.pos = ins ? ins_pos : in_item.position;
  assign cmd.len = len_r;
  assign cmd.ch  = in_item.char_value;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [CHAR_W-1:0] lower_d, upper_d;
      if (gi == 0) begin : g_lo0
        assign lower_d = '0;
      end else begin : g_lo
        assign lower_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_hi0
        assign upper_d = '0;
      end else begin : g_hi
        assign upper_d = cell_data[gi+1];
      end
      bxc_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .sel        (sel_r),
        .idx        (IDX_W'(gi)),
        .lower_data (lower_d),
        .upper_data (upper_d),
        .data       (cell_data[gi]),
        .rd_mask    (cell_rd[gi]),
        .last_mask  (cell_last[gi])
      );
    end
  endgenerate

  bxc_gather u_gather (
    .clk       (clk),
    .rd_mask   (cell_rd),
    .last_mask (cell_last),
    .rd_char   (rd_char),
    .last_char (last_char)
  );

  always_comb begin
    phase_nxt  = phase_r;
    strobe_nxt = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_MASK;
        end
      end
      PH_MASK: phase_nxt = PH_GRP;
      PH_GRP:  phase_nxt = PH_OUT;
      PH_OUT: begin
        phase_nxt  = PH_IDLE;
        strobe_nxt = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    out_nxt            = out_r;
    out_nxt.read_char  = rd_char;
    out_nxt.first_char = (len_r != '0) ? cell_data[0] : '0;
    out_nxt.last_char  = last_char;
    out_nxt.length_now = len_r;
    out_nxt.is_empty   = (len_r == '0);
    out_nxt.status     = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      len_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      strobe_r <= strobe_nxt;
      if (accept) begin
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      sel_r    <= sel_nxt;
    end
    if (phase_r == PH_OUT) begin
      out_r <= out_nxt;
    end
  end

  assign busy       = (phase_r != PH_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire
